@@ hdl/slid_pkg.sv @@
// slid_pkg: shared types and constants for the sorted list insert/delete unit
// depends on nothing; used by slid_cell and sorted_list_insert_delete_unit
`timescale 1ns / 1ps

package slid_pkg;

  // store geometry
  localparam int unsigned Capacity = 64;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned CountW   = $clog2(Capacity + 1);

  // operation codes
  localparam logic KindInsert = 1'b0;
  localparam logic KindDelete = 1'b1;

  // status codes
  localparam logic [1:0] StatusDone     = 2'd0;
  localparam logic [1:0] StatusFull     = 2'd1;
  localparam logic [1:0] StatusEmpty    = 2'd2;
  localparam logic [1:0] StatusNotFound = 2'd3;

  // input item
  typedef struct packed {
    logic                     kind;
    logic signed [ValueW-1:0] value;
  } in_item_t;

  // result item
  typedef struct packed {
    logic        [1:0]        status;
    logic        [CountW-1:0] count;
    logic signed [ValueW-1:0] smallest;
    logic signed [ValueW-1:0] largest;
  } out_item_t;

  // command broadcast to every cell
  typedef struct packed {
    logic                     ins_en;
    logic                     del_en;
    logic signed [ValueW-1:0] value;
  } cell_cmd_t;

endpackage

@@ hdl/slid_cell.sv @@
// slid_cell: one entry of the sorted row, compares against the broadcast value
// and takes its own, the new, the left or the right neighbor's value; uses slid_pkg
`timescale 1ns / 1ps

module slid_cell (
  input  logic                              clk_i,
  input  slid_pkg::cell_cmd_t               cmd_i,
  input  logic                              occ_i,
  input  logic                              left_lt_i,
  input  logic signed [slid_pkg::ValueW-1:0] left_val_i,
  input  logic signed [slid_pkg::ValueW-1:0] right_val_i,
  output logic                              lt_o,
  output logic                              eq_o,
  output logic signed [slid_pkg::ValueW-1:0] val_o
);

  logic signed [slid_pkg::ValueW-1:0] val_q, val_d;
  logic                               less;

  // compare held value against the broadcast value
  assign less = val_q < cmd_i.value;
  assign lt_o = occ_i && less;
  assign eq_o = occ_i && (val_q == cmd_i.value);
  assign val_o = val_q;

  // insert opens a slot at the first cell not below the value, delete closes
  // the gap from the first cell not below the value onward
  always_comb begin
    val_d = val_q;
    if (cmd_i.ins_en && !lt_o) begin
      if (left_lt_i) begin
        val_d = cmd_i.value;
      end else begin
        val_d = left_val_i;
      end
    end else if (cmd_i.del_en && occ_i && !less) begin
      val_d = right_val_i;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

@@ hdl/sorted_list_insert_delete_unit.sv @@
// sorted_list_insert_delete_unit: top level, item handshake, count and status
// control around a row of slid_cell entries; uses slid_pkg and slid_cell
`timescale 1ns / 1ps

// Keeps up to slid_pkg::Capacity signed 32-bit values in ascending order in a
// row of cells, each holding one entry and trading values with its neighbors.
// An item either inserts its value at the sorted place or deletes one equal
// entry, and yields one result with status, count, and the smallest and
// largest values held (zero when empty). An item is captured in the item
// register when accepted; in the execute state all cells compare in parallel
// and shift by one place, and in the report state the end entries of the
// updated row are picked into the result register. A new item is taken only
// in the idle state, after the previous item has been reported. The result
// register lets the next item be accepted while a result still waits; the last
// step stalls only when a result is still unclaimed at the time the next one
// is ready.

module sorted_list_insert_delete_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  slid_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output slid_pkg::out_item_t out_item_o
);

  localparam int unsigned N  = slid_pkg::Capacity;
  localparam int unsigned CW = slid_pkg::CountW;
  localparam int unsigned VW = slid_pkg::ValueW;

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StExec   = 2'd1;
  localparam logic [1:0] StReport = 2'd2;

  logic [1:0]          state_q, state_d;
  slid_pkg::in_item_t  item_q;
  logic [CW-1:0]       count_q, count_d;
  logic [1:0]          status_q, status_d;
  slid_pkg::out_item_t out_q;
  logic                out_valid_q, out_valid_d;
  logic                load_out;
  logic                found;
  logic                is_full;
  slid_pkg::cell_cmd_t cmd;

  logic        [N-1:0]  occ;
  logic        [N-1:0]  lt;
  logic        [N-1:0]  eq;
  logic        [N-1:0]  last;
  logic signed [VW-1:0] vals [N];
  logic signed [VW-1:0] largest_sel;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // occupancy of each cell and the end marker of the list
  for (genvar i = 0; i < N; i++) begin : g_occ
    assign occ[i] = count_q > CW'(i);
    if (i == N - 1) begin : g_tail
      assign last[i] = occ[i];
    end else begin : g_mid
      assign last[i] = occ[i] && (count_q <= CW'(i + 1));
    end
  end

  // row of cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                 left_lt;
    logic signed [VW-1:0] left_val;
    logic signed [VW-1:0] right_val;
    if (i == 0) begin : g_first
      assign left_lt  = 1'b1;
      assign left_val = '0;
    end else begin : g_inner_l
      assign left_lt  = lt[i-1];
      assign left_val = vals[i-1];
    end
    if (i == N - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_inner_r
      assign right_val = vals[i+1];
    end
    slid_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .occ_i       (occ[i]),
      .left_lt_i   (left_lt),
      .left_val_i  (left_val),
      .right_val_i (right_val),
      .lt_o        (lt[i]),
      .eq_o        (eq[i]),
      .val_o       (vals[i])
    );
  end

  // operation decode
  assign found   = |eq;
  assign is_full = (count_q == CW'(N));

  always_comb begin
    cmd.value  = item_q.value;
    cmd.ins_en = (state_q == StExec) && (item_q.kind == slid_pkg::KindInsert) && !is_full;
    cmd.del_en = (state_q == StExec) && (item_q.kind == slid_pkg::KindDelete) && found;
  end

  // status and count
  always_comb begin
    status_d = status_q;
    count_d  = count_q;
    if (state_q == StExec) begin
      if (item_q.kind == slid_pkg::KindInsert) begin
        status_d = is_full ? slid_pkg::StatusFull : slid_pkg::StatusDone;
      end else if (count_q == '0) begin
        status_d = slid_pkg::StatusEmpty;
      end else begin
        status_d = found ? slid_pkg::StatusDone : slid_pkg::StatusNotFound;
      end
      if (cmd.ins_en) begin
        count_d = count_q + CW'(1);
      end else if (cmd.del_en) begin
        count_d = count_q - CW'(1);
      end
    end
  end

  // largest entry: select the cell at the end of the list
  always_comb begin
    largest_sel = '0;
    for (int i = 0; i < N; i++) begin
      largest_sel = largest_sel | (vals[i] & {VW{last[i]}});
    end
  end

  // sequencing
  assign load_out = (state_q == StReport) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StExec;
        end
      end
      StExec: begin
        state_d = StReport;
      end
      StReport: begin
        if (load_out) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
    status_q <= status_d;
    if (load_out) begin
      out_q.status   <= status_q;
      out_q.count    <= count_q;
      out_q.smallest <= (count_q != '0) ? vals[0] : '0;
      out_q.largest  <= largest_sel;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(N))
    else $error("entry count above capacity");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.ins_en, cmd.del_en}))
    else $error("insert and delete in the same cycle");

  a_del_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.del_en |-> (count_q != '0))
    else $error("delete applied to an empty row");

  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StExec && item_q.kind == slid_pkg::KindInsert && is_full)
      |=> (count_q == CW'(N)) && (status_q == slid_pkg::StatusFull))
    else $error("refused insert changed the count");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == StExec))
    else $error("accepted item not executed next cycle");

endmodule
